// ===== hdl/cpt_pkg.sv =====
// ============================================================================
// cpt_pkg: shared types and constants for the Clarke/Park CORDIC transform
// Holds the payload structs that pass between the pipeline sections, the
// CORDIC arctangent table and the fixed-point constants of the datapath.
// ============================================================================
package cpt_pkg;

  // Number of entries in the arctangent table.
  localparam int AtanEntries = 24;

  // 1/sqrt(3) in Q30.
  localparam logic signed [46:0] INV_SQRT3_Q30 = 47'sd619925131;

  // Q16 alpha is 21845*n plus the rounded n/3 term.
  localparam logic signed [32:0] ALPHA_Q16_SCALE = 33'sd21845;

  // Offset that makes n+1 non-negative as a multiple of three (3*2^16 + 1).
  localparam logic signed [19:0] DIV3_OFFSET = 20'sd196609;

  // ceil(2^20 / 3): exact floor division by three for 19-bit operands.
  localparam logic [36:0] DIV3_RECIP = 37'd349526;

  // Quotient bias removed after the offset division (2^16).
  localparam logic [16:0] DIV3_BIAS = 17'd65536;

  // CORDIC start vector, 1.0 in Q30.
  localparam logic signed [32:0] CORDIC_X0 = 33'sd1073741824;

  // Quarter turn in angle counts.
  localparam logic signed [15:0] QUARTER_TURN = 16'sd16384;

  // Arctangent of 2^-i, full turn = 2^32.
  localparam logic [29:0] ATAN_TURNS [AtanEntries] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4,
    30'h028B0D43, 30'h0145D7E1, 30'h00A2F61E, 30'h00517C55,
    30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
    30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D,
    30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
    30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051
  };

  // Stationary-frame results that ride along with the CORDIC.
  typedef struct packed {
    logic signed [16:0] alpha_o;  // rounded alpha, output format
    logic signed [16:0] beta_o;   // rounded beta, output format
    logic signed [32:0] alpha_f;  // alpha in Q16
    logic signed [32:0] beta_f;   // beta in Q16
    logic               neg;      // angle was folded by a half turn
  } cpt_side_t;

  // CORDIC vector and residual angle.
  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
  } cpt_vec_t;

  // Q30 gain compensation for a given number of CORDIC steps. Evaluated at
  // elaboration only: the gain product is built one step at a time, then
  // its square root is taken bit by bit.
  function automatic logic [30:0] cordic_gain(input int steps);
    logic [63:0] k2;
    logic [63:0] q;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    k2 = 64'd1 << 30;
    for (int i = 0; i < AtanEntries; i++) begin
      if (i < steps) begin
        case (i)
          0:  q = (k2 + 64'd1) / 64'd2;
          1:  q = (k2 + 64'd2) / 64'd5;
          2:  q = (k2 + 64'd8) / 64'd17;
          3:  q = (k2 + 64'd32) / 64'd65;
          4:  q = (k2 + 64'd128) / 64'd257;
          5:  q = (k2 + 64'd512) / 64'd1025;
          6:  q = (k2 + 64'd2048) / 64'd4097;
          7:  q = (k2 + 64'd8192) / 64'd16385;
          8:  q = (k2 + 64'd32768) / 64'd65537;
          9:  q = (k2 + 64'd131072) / 64'd262145;
          10: q = (k2 + 64'd524288) / 64'd1048577;
          11: q = (k2 + 64'd2097152) / 64'd4194305;
          12: q = (k2 + 64'd8388608) / 64'd16777217;
          13: q = (k2 + 64'd33554432) / 64'd67108865;
          14: q = (k2 + 64'd134217728) / 64'd268435457;
          15: q = (k2 + 64'd536870912) / 64'd1073741825;
          default: q = 64'd0;  // later steps no longer change the product
        endcase
        k2 = k2 - q;
      end
    end
    v = k2 << 30;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (b > v) b = b >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (b != 64'd0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r[30:0];
  endfunction

endpackage

// ===== hdl/cpt_clarke.sv =====
// ============================================================================
// cpt_clarke: four-stage Clarke transform front end
// Forms alpha and beta in output and Q16 formats and folds the rotor angle
// into plus or minus a quarter turn for the CORDIC.
// ============================================================================
module cpt_clarke (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [15:0]     in_phase_a,
  input  logic signed [15:0]     in_phase_b,
  input  logic signed [15:0]     in_phase_c,
  input  logic [15:0]            in_angle,
  output logic                   out_valid,
  input  logic                   out_ready,
  output cpt_pkg::cpt_side_t     out_side,
  output logic signed [15:0]     out_angle
);
  import cpt_pkg::*;

  localparam int NS = 4;

  logic v_r [NS];
  logic adv [NS];

  // Stage 1 registers.
  logic signed [17:0] n1_r;
  logic signed [16:0] bc1_r;
  logic signed [15:0] ang1_r;
  logic               neg1_r;
  // Stage 2 registers.
  logic [18:0]        u2_r;
  logic signed [32:0] a21_2_r;
  logic signed [46:0] p2_r;
  logic signed [15:0] ang2_r;
  logic               neg2_r;
  // Stage 3 registers.
  logic [36:0]        q3_r;
  logic signed [32:0] a21_3_r;
  logic signed [32:0] betaf3_r;
  logic signed [16:0] betao3_r;
  logic signed [15:0] ang3_r;
  logic               neg3_r;
  // Stage 4 registers.
  cpt_side_t          side4_r;
  logic signed [15:0] ang4_r;

  // Next values.
  logic signed [17:0] n1_nxt;
  logic signed [16:0] bc1_nxt;
  logic signed [15:0] ang_s;
  logic signed [15:0] ang1_nxt;
  logic               neg1_nxt;
  logic signed [19:0] u_sum;
  logic signed [46:0] pr14;
  logic signed [46:0] pr30;
  logic [16:0]        quot3;
  cpt_side_t          side4_nxt;

  // A stage loads when it is empty or its item moves on.
  assign adv[NS-1] = ~v_r[NS-1] | out_ready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_adv
    assign adv[k] = ~v_r[k] | adv[k+1];
  end
  assign in_ready = adv[0];

  // Stage 1: phase combinations and half-turn fold of the angle.
  always_comb begin
    n1_nxt   = 18'(in_phase_a) + 18'(in_phase_a) - 18'(in_phase_b) - 18'(in_phase_c);
    bc1_nxt  = 17'(in_phase_b) - 17'(in_phase_c);
    ang_s    = $signed(in_angle);
    neg1_nxt = (ang_s > QUARTER_TURN) || (ang_s < -QUARTER_TURN);
    // Adding or removing a half turn only flips the sign bit.
    ang1_nxt = neg1_nxt ? {~ang_s[15], ang_s[14:0]} : ang_s;
  end

  // Stage 2: offset for the divide by three and the scaling multiplies.
  assign u_sum = 20'(n1_r) + DIV3_OFFSET;

  // Stage 3: rounding of beta, ties away from zero.
  assign pr14 = p2_r + (p2_r[46] ? 47'sd8191 : 47'sd8192);
  assign pr30 = p2_r + (p2_r[46] ? 47'sd536870911 : 47'sd536870912);

  // Stage 4: floor((n+1)/3) gives alpha rounded; Q16 alpha adds 21845*n.
  assign quot3 = q3_r[36:20];
  always_comb begin
    side4_nxt.alpha_o = quot3 - DIV3_BIAS;
    side4_nxt.alpha_f = a21_3_r + $signed({16'b0, quot3}) - $signed({16'b0, DIV3_BIAS});
    side4_nxt.beta_o  = betao3_r;
    side4_nxt.beta_f  = betaf3_r;
    side4_nxt.neg     = neg3_r;
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) v_r[k] <= 1'b0;
    end else begin
      if (adv[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      n1_r   <= n1_nxt;
      bc1_r  <= bc1_nxt;
      ang1_r <= ang1_nxt;
      neg1_r <= neg1_nxt;
    end
    if (adv[1]) begin
      u2_r    <= u_sum[18:0];
      a21_2_r <= 33'(n1_r) * ALPHA_Q16_SCALE;
      p2_r    <= 47'(bc1_r) * INV_SQRT3_Q30;
      ang2_r  <= ang1_r;
      neg2_r  <= neg1_r;
    end
    if (adv[2]) begin
      q3_r     <= 37'(u2_r) * DIV3_RECIP;
      a21_3_r  <= a21_2_r;
      betaf3_r <= pr14[46:14];
      betao3_r <= pr30[46:30];
      ang3_r   <= ang2_r;
      neg3_r   <= neg2_r;
    end
    if (adv[3]) begin
      side4_r <= side4_nxt;
      ang4_r  <= ang3_r;
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_side  = side4_r;
  assign out_angle = ang4_r;

endmodule

// ===== hdl/cpt_cordic.sv =====
// ============================================================================
// cpt_cordic: unrolled rotation-mode CORDIC pipeline
// One register stage per micro-rotation; the stationary-frame results ride
// along so they arrive at the Park stages together with cos and sin.
// ============================================================================
module cpt_cordic #(
  parameter int ITERATIONS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  cpt_pkg::cpt_side_t     in_side,
  input  logic signed [15:0]     in_angle,
  output logic                   out_valid,
  input  logic                   out_ready,
  output cpt_pkg::cpt_side_t     out_side,
  output logic signed [32:0]     out_x,
  output logic signed [32:0]     out_y
);
  import cpt_pkg::*;

  localparam int NSTEP = (ITERATIONS < AtanEntries) ? ITERATIONS : AtanEntries;

  logic      v_r    [NSTEP];
  logic      adv    [NSTEP];
  cpt_vec_t  st_r   [NSTEP];
  cpt_side_t side_r [NSTEP];

  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    cpt_vec_t           src;
    cpt_vec_t           nxt;
    cpt_side_t          src_side;
    logic               src_v;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] at;

    // Stage input: the start vector for the first step, else the prior stage.
    if (i == 0) begin : g_first
      assign src.x    = CORDIC_X0;
      assign src.y    = '0;
      assign src.z    = $signed({in_angle[15], in_angle, 16'h0000});
      assign src_side = in_side;
      assign src_v    = in_valid;
    end else begin : g_next
      assign src      = st_r[i-1];
      assign src_side = side_r[i-1];
      assign src_v    = v_r[i-1];
    end

    // Handshake back-pressure chain.
    if (i == NSTEP - 1) begin : g_last
      assign adv[i] = ~v_r[i] | out_ready;
    end else begin : g_mid
      assign adv[i] = ~v_r[i] | adv[i+1];
    end

    // One micro-rotation toward zero residual angle.
    assign dx = src.y >>> i;
    assign dy = src.x >>> i;
    assign at = $signed({3'b000, ATAN_TURNS[i]});
    always_comb begin
      if (src.z > 33'sd0) begin
        nxt.x = src.x - dx;
        nxt.y = src.y + dy;
        nxt.z = src.z - at;
      end else begin
        nxt.x = src.x + dx;
        nxt.y = src.y - dy;
        nxt.z = src.z + at;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (adv[i]) begin
        v_r[i] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[i]) begin
        st_r[i]   <= nxt;
        side_r[i] <= src_side;
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[NSTEP-1];
  assign out_side  = side_r[NSTEP-1];
  assign out_x     = st_r[NSTEP-1].x;
  assign out_y     = st_r[NSTEP-1].y;

endmodule

// ===== hdl/cpt_park.sv =====
// ============================================================================
// cpt_park: gain compensation and Park rotation, five stages
// Scales the CORDIC vector to cos and sin in Q24 (sign applied for a folded
// angle), forms the four cross products and rounds d and q.
// ============================================================================
module cpt_park #(
  parameter int ITERATIONS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  cpt_pkg::cpt_side_t     in_side,
  input  logic signed [32:0]     in_x,
  input  logic signed [32:0]     in_y,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [16:0]     out_alpha,
  output logic signed [16:0]     out_beta,
  output logic signed [17:0]     out_direct,
  output logic signed [17:0]     out_quad
);
  import cpt_pkg::*;

  localparam int NS = 5;
  localparam int NSTEP = (ITERATIONS < AtanEntries) ? ITERATIONS : AtanEntries;
  localparam logic [30:0]        GAIN = cordic_gain(NSTEP);
  localparam logic signed [31:0] KPOS = $signed({1'b0, GAIN});
  localparam logic signed [31:0] KNEG = -KPOS;

  logic v_r [NS];
  logic adv [NS];

  logic signed [62:0] px1_r, py1_r;
  cpt_side_t          side1_r;
  logic signed [25:0] cs2_r, sn2_r;
  cpt_side_t          side2_r;
  logic signed [58:0] ac3_r, bs3_r, bc3_r, as3_r;
  cpt_side_t          side3_r;
  logic signed [59:0] dsum4_r, qsum4_r;
  cpt_side_t          side4_r;
  logic signed [16:0] alpha5_r, beta5_r;
  logic signed [17:0] d5_r, q5_r;

  logic signed [31:0] ks;
  logic signed [62:0] pxr, pyr;
  logic signed [59:0] dr, qr;

  // Back-pressure chain.
  assign adv[NS-1] = ~v_r[NS-1] | out_ready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_adv
    assign adv[k] = ~v_r[k] | adv[k+1];
  end
  assign in_ready = adv[0];

  // A folded angle negates cos and sin; folding the sign into the gain
  // keeps the negation out of the datapath.
  assign ks = in_side.neg ? KNEG : KPOS;

  // Rounding to nearest, ties away from zero.
  assign pxr = px1_r + (px1_r[62] ? 63'sd34359738367 : 63'sd34359738368);
  assign pyr = py1_r + (py1_r[62] ? 63'sd34359738367 : 63'sd34359738368);
  assign dr  = dsum4_r + (dsum4_r[59] ? 60'sd549755813887 : 60'sd549755813888);
  assign qr  = qsum4_r + (qsum4_r[59] ? 60'sd549755813887 : 60'sd549755813888);

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) v_r[k] <= 1'b0;
    end else begin
      if (adv[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      px1_r   <= 63'(in_x) * 63'(ks);
      py1_r   <= 63'(in_y) * 63'(ks);
      side1_r <= in_side;
    end
    if (adv[1]) begin
      cs2_r   <= pxr[61:36];
      sn2_r   <= pyr[61:36];
      side2_r <= side1_r;
    end
    if (adv[2]) begin
      ac3_r   <= 59'(side2_r.alpha_f) * 59'(cs2_r);
      bs3_r   <= 59'(side2_r.beta_f) * 59'(sn2_r);
      bc3_r   <= 59'(side2_r.beta_f) * 59'(cs2_r);
      as3_r   <= 59'(side2_r.alpha_f) * 59'(sn2_r);
      side3_r <= side2_r;
    end
    if (adv[3]) begin
      dsum4_r <= 60'(ac3_r) + 60'(bs3_r);
      qsum4_r <= 60'(bc3_r) - 60'(as3_r);
      side4_r <= side3_r;
    end
    if (adv[4]) begin
      alpha5_r <= side4_r.alpha_o;
      beta5_r  <= side4_r.beta_o;
      d5_r     <= dr[57:40];
      q5_r     <= qr[57:40];
    end
  end

  assign out_valid  = v_r[NS-1];
  assign out_alpha  = alpha5_r;
  assign out_beta   = beta5_r;
  assign out_direct = d5_r;
  assign out_quad   = q5_r;

endmodule

// ===== hdl/clarke_park_cordic_transform_top.sv =====
// ============================================================================
// clarke_park_cordic_transform_top: streaming Clarke/Park transform
// Three-phase currents and rotor angle in; alpha, beta, d and q out.
// ============================================================================
// Register stages: 4 Clarke, one per CORDIC step, 5 Park; each has its own
// valid bit. Throughput: one transfer per cycle on each side while out_ready
// is high, and a stalled output holds while empty stages fill.
// Reset (synchronous, active low) clears all valid bits; data is not reset.
module clarke_park_cordic_transform_top #(
  parameter int ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_phase_a_current,
  input  logic signed [15:0] in_phase_b_current,
  input  logic signed [15:0] in_phase_c_current,
  input  logic [15:0]        in_rotor_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] out_alpha_current,
  output logic signed [16:0] out_beta_current,
  output logic signed [17:0] out_direct_current,
  output logic signed [17:0] out_quadrature_current
);
  import cpt_pkg::*;

  logic               cl_valid, cl_ready;
  cpt_side_t          cl_side;
  logic signed [15:0] cl_angle;
  logic               co_valid, co_ready;
  cpt_side_t          co_side;
  logic signed [32:0] co_x, co_y;

  // Clarke front end.
  cpt_clarke u_clarke (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_phase_a (in_phase_a_current),
    .in_phase_b (in_phase_b_current),
    .in_phase_c (in_phase_c_current),
    .in_angle   (in_rotor_angle),
    .out_valid  (cl_valid),
    .out_ready  (cl_ready),
    .out_side   (cl_side),
    .out_angle  (cl_angle)
  );

  // Sine and cosine generation.
  cpt_cordic #(.ITERATIONS(ITERATIONS)) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cl_valid),
    .in_ready  (cl_ready),
    .in_side   (cl_side),
    .in_angle  (cl_angle),
    .out_valid (co_valid),
    .out_ready (co_ready),
    .out_side  (co_side),
    .out_x     (co_x),
    .out_y     (co_y)
  );

  // Gain compensation, Park rotation and output register.
  cpt_park #(.ITERATIONS(ITERATIONS)) u_park (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (co_valid),
    .in_ready   (co_ready),
    .in_side    (co_side),
    .in_x       (co_x),
    .in_y       (co_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_alpha  (out_alpha_current),
    .out_beta   (out_beta_current),
    .out_direct (out_direct_current),
    .out_quad   (out_quadrature_current)
  );

endmodule

// ===== hdl/cpt_checker.sv =====
// ============================================================================
// cpt_checker: port-level checks for the Clarke/Park transform
// Tracks items in flight and checks reset, back-pressure and occupancy rules
// seen at the top-level ports.
// ============================================================================
module cpt_checker #(
  parameter int ITERATIONS = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [16:0] out_alpha_current,
  input logic signed [16:0] out_beta_current,
  input logic signed [17:0] out_direct_current,
  input logic signed [17:0] out_quadrature_current
);
  import cpt_pkg::*;

  localparam int NSTEP = (ITERATIONS < AtanEntries) ? ITERATIONS : AtanEntries;
  localparam int DEPTH = NSTEP + 9;
  localparam int OW    = $clog2(DEPTH + 2) + 1;

  logic [OW-1:0] occ_r;
  logic [OW-1:0] occ_nxt;
  logic          in_xfer, out_xfer;

  assign in_xfer  = in_valid & in_ready;
  assign out_xfer = out_valid & out_ready;

  // Items accepted but not yet delivered.
  always_comb begin
    occ_nxt = occ_r;
    if (in_xfer && !out_xfer) occ_nxt = occ_r + 1'b1;
    if (!in_xfer && out_xfer) occ_nxt = occ_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A result is only offered for an item that was accepted.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> occ_r != '0)
    else $error("result offered with no item in flight");

  // The pipeline never holds more items than it has stages.
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OW'(DEPTH))
    else $error("more items in flight than pipeline stages");

  // An empty or draining output stage never blocks the input.
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input blocked while output side can move");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_alpha_current) &&
      $stable(out_beta_current) && $stable(out_direct_current) &&
      $stable(out_quadrature_current))
    else $error("stalled result changed or dropped");

endmodule

bind clarke_park_cordic_transform_top cpt_checker #(.ITERATIONS(ITERATIONS)) u_cpt_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_valid               (in_valid),
  .in_ready               (in_ready),
  .out_valid              (out_valid),
  .out_ready              (out_ready),
  .out_alpha_current      (out_alpha_current),
  .out_beta_current       (out_beta_current),
  .out_direct_current     (out_direct_current),
  .out_quadrature_current (out_quadrature_current)
);
